// ===== rtl/core/pdcch_ss_pkg.sv =====
// Shared constants, control types and candidate counting for the PDCCH search space generator.
`timescale 1ns / 1ps

package pdcch_ss_pkg;

  localparam int CCE_COUNT_MAX = 127;
  localparam int MAX_LIST_DEF  = 16;
  localparam int NCCE_W        = 7;
  localparam int SF_W          = 4;
  localparam int RNTI_W        = 16;
  localparam int FILT_W        = 3;
  localparam int CFG_W         = 5;
  localparam int CFG_RESET     = 16;
  localparam int Y_W           = 17;
  localparam int PROD_W        = 32;
  localparam int HALF_W        = 16;
  localparam int HASH_MULT     = 39827;
  localparam int HASH_MOD      = 65537;
  localparam int COMMON_SPAN   = 16;
  localparam int CNT_W         = 3;
  localparam int SUM_W         = 5;
  localparam int DIV_CNT_W     = 5;
  localparam int IDX_W         = 4;

  localparam logic [CNT_W-1:0] CANDS_PER_LEVEL [4] = '{3'd6, 3'd6, 3'd2, 3'd2};

  typedef struct packed {
    logic load;
    logic hash_mul;
    logic hash_red;
    logic lvl_next;
    logic div_load;
    logic div_step;
    logic cand_init;
    logic emit;
    logic mark;
  } pdcch_ss_cmd_t;

  typedef struct packed {
    logic is_common;
    logic hash_done;
    logic total_zero;
    logic lvl_empty;
    logic div_done;
    logic emit_last;
    logic lvl_last;
    logic out_free;
  } pdcch_ss_sts_t;

  // Number of distinct candidates that one aggregation level contributes.
  function automatic logic [CNT_W-1:0] level_count(input logic common,
                                                   input logic [NCCE_W-1:0] ncce,
                                                   input logic [FILT_W-1:0] filt,
                                                   input logic [1:0] lvl);
    logic [NCCE_W-1:0] span;
    logic [NCCE_W-1:0] n;
    logic              en;
    span = (ncce < NCCE_W'(COMMON_SPAN)) ? ncce : NCCE_W'(COMMON_SPAN);
    n    = ncce >> lvl;
    en   = (filt == '0) || (filt == ({1'b0, lvl} + 3'd1));
    if (common) begin
      level_count = (lvl >= 2'd2) ? CNT_W'(span >> lvl) : '0;
    end else if (!en) begin
      level_count = '0;
    end else if (n < NCCE_W'(CANDS_PER_LEVEL[lvl])) begin
      level_count = CNT_W'(n);
    end else begin
      level_count = CANDS_PER_LEVEL[lvl];
    end
  endfunction

endpackage

// ===== rtl/core/pdcch_search_space_candidates_top.sv =====
// Top level of the PDCCH search space candidate generator.
// Each input item is one request: search space type, CCE count, subframe, RNTI and a
// level filter. The block answers with one output item per decoding candidate, in
// order of aggregation level 1, 2, 4 and 8, numbered from zero, with last set on the
// final one. A request without any candidate yields one item with valid_res low.
// Both channels use valid and stall. The user must write the one configuration register
// (candidate limit) through cfg_we_i and cfg_wdata_i only while the block is idle;
// the block itself does not enforce this. One request is handled at a time. A
// UE-specific request spends a setup state, then the hash steps (one multiply and one
// fold per step, for each subframe from zero up to the given one), one check per
// aggregation level, and for each contributing level a run of the bit-serial remainder
// unit followed by one item per candidate. A common request takes the setup state, the
// level checks and one item per candidate. An empty list ends with the marker item.
// The next request is taken as soon as the last item of the previous one sits in the
// output register. A stalled receiver holds the output item and the block waits.
// Reset empties the output register, returns the sequencer to idle and sets the
// candidate limit to 16.
`timescale 1ns / 1ps

module pdcch_search_space_candidates_top import pdcch_ss_pkg::*; #(
  parameter int MAX_LIST = MAX_LIST_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [NCCE_W-1:0] nof_cce_i,
  input  logic [SF_W-1:0]   subframe_i,
  input  logic [RNTI_W-1:0] rnti_i,
  input  logic [FILT_W-1:0] level_filter_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              valid_res_o,
  output logic [1:0]        level_log2_o,
  output logic [NCCE_W-1:0] start_cce_o,
  output logic [IDX_W-1:0]  cand_index_o,
  output logic              last_o
);

  pdcch_ss_cmd_t cmd;
  pdcch_ss_sts_t sts;

  pdcch_ss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pdcch_ss_dp #(
    .MAX_LIST (MAX_LIST)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (action_i),
    .nof_cce_i      (nof_cce_i),
    .subframe_i     (subframe_i),
    .rnti_i         (rnti_i),
    .level_filter_i (level_filter_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .valid_res_o    (valid_res_o),
    .level_log2_o   (level_log2_o),
    .start_cce_o    (start_cce_o),
    .cand_index_o   (cand_index_o),
    .last_o         (last_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// ===== rtl/core/pdcch_ss_ctrl.sv =====
// Sequencing state machine of the PDCCH search space generator.
`timescale 1ns / 1ps

module pdcch_ss_ctrl import pdcch_ss_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pdcch_ss_sts_t sts_i,
  output pdcch_ss_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_START    = 8'b0000_0010,
    ST_HASH_MUL = 8'b0000_0100,
    ST_HASH_RED = 8'b0000_1000,
    ST_LVL      = 8'b0001_0000,
    ST_DIV      = 8'b0010_0000,
    ST_EMIT     = 8'b0100_0000,
    ST_MARK     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        state_d = sts_i.is_common ? ST_LVL : ST_HASH_MUL;
      end
      ST_HASH_MUL: begin
        cmd_o.hash_mul = 1'b1;
        state_d        = ST_HASH_RED;
      end
      ST_HASH_RED: begin
        cmd_o.hash_red = 1'b1;
        state_d        = sts_i.hash_done ? ST_LVL : ST_HASH_MUL;
      end
      ST_LVL: begin
        if (sts_i.total_zero) begin
          state_d = ST_MARK;
        end else if (sts_i.lvl_empty) begin
          cmd_o.lvl_next = 1'b1;
        end else if (sts_i.is_common) begin
          cmd_o.cand_init = 1'b1;
          state_d         = ST_EMIT;
        end else begin
          cmd_o.div_load = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end else if (sts_i.lvl_last) begin
            state_d = ST_LVL;
          end
        end
      end
      ST_MARK: begin
        if (sts_i.out_free) begin
          cmd_o.mark = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/pdcch_ss_dp.sv =====
// Datapath of the PDCCH search space generator: hash, remainder unit, counters, output register.
`timescale 1ns / 1ps

module pdcch_ss_dp import pdcch_ss_pkg::*; #(
  parameter int MAX_LIST = MAX_LIST_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                action_i,
  input  logic [NCCE_W-1:0]   nof_cce_i,
  input  logic [SF_W-1:0]     subframe_i,
  input  logic [RNTI_W-1:0]   rnti_i,
  input  logic [FILT_W-1:0]   level_filter_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                valid_res_o,
  output logic [1:0]          level_log2_o,
  output logic [NCCE_W-1:0]   start_cce_o,
  output logic [IDX_W-1:0]    cand_index_o,
  output logic                last_o,
  input  pdcch_ss_cmd_t       cmd_i,
  output pdcch_ss_sts_t       sts_o
);

  localparam int KW = $clog2(MAX_LIST + 1);

  logic [CFG_W-1:0]     max_cand_q;
  logic                 common_q;
  logic [NCCE_W-1:0]    ncce_q;
  logic [SF_W-1:0]      sf_q;
  logic [FILT_W-1:0]    filt_q;
  logic [KW-1:0]        limit_q;
  logic [Y_W-1:0]       y_q;
  logic [PROD_W-1:0]    prod_q;
  logic [SF_W-1:0]      step_q;
  logic [1:0]           lvl_q;
  logic [NCCE_W-1:0]    r_q;
  logic [CNT_W-1:0]     m_q;
  logic [KW-1:0]        k_q;
  logic [Y_W-1:0]       divq_q;
  logic [DIV_CNT_W-1:0] divcnt_q;
  logic                 out_valid_q;
  logic                 valid_res_q;
  logic [1:0]           level_log2_q;
  logic [NCCE_W-1:0]    start_cce_q;
  logic [IDX_W-1:0]     cand_index_q;
  logic                 last_q;

  logic [NCCE_W-1:0]    ncce_sat;
  logic [KW-1:0]        limit_sat;
  logic [Y_W-1:0]       y_red;
  logic [NCCE_W-1:0]    n_cur;
  logic [NCCE_W:0]      trial;
  logic [NCCE_W:0]      rem;
  logic [NCCE_W-1:0]    r_inc;
  logic [CNT_W-1:0]     lvl_cnt;
  logic [SUM_W-1:0]     sum;
  logic [KW-1:0]        total;
  logic                 out_free;

  assign ncce_sat  = (32'(nof_cce_i) > CCE_COUNT_MAX) ? NCCE_W'(CCE_COUNT_MAX) : nof_cce_i;
  assign limit_sat = (32'(max_cand_q) > MAX_LIST) ? KW'(MAX_LIST) : KW'(max_cand_q);

  // Fold of the product modulo 65537, using 65536 = -1.
  always_comb begin
    if (prod_q[HALF_W-1:0] >= prod_q[PROD_W-1:HALF_W]) begin
      y_red = Y_W'(prod_q[HALF_W-1:0] - prod_q[PROD_W-1:HALF_W]);
    end else begin
      y_red = Y_W'(18'(prod_q[HALF_W-1:0]) + 18'(HASH_MOD) - 18'(prod_q[PROD_W-1:HALF_W]));
    end
  end

  assign n_cur = ncce_q >> lvl_q;
  assign trial = {r_q, divq_q[Y_W-1]};
  assign rem   = (trial >= {1'b0, n_cur}) ? (trial - {1'b0, n_cur}) : trial;
  assign r_inc = ((r_q + 7'd1) == n_cur) ? '0 : (r_q + 7'd1);

  assign lvl_cnt = level_count(common_q, ncce_q, filt_q, lvl_q);

  always_comb begin
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      sum = sum + SUM_W'(level_count(common_q, ncce_q, filt_q, 2'(i)));
    end
  end

  assign total    = (32'(sum) > 32'(limit_q)) ? limit_q : KW'(sum);
  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.is_common  = common_q;
  assign sts_o.hash_done  = (step_q == sf_q);
  assign sts_o.total_zero = (total == '0);
  assign sts_o.lvl_empty  = (lvl_cnt == '0);
  assign sts_o.div_done   = (divcnt_q == DIV_CNT_W'(Y_W - 1));
  assign sts_o.emit_last  = (((KW + 1)'(k_q) + (KW + 1)'(1)) == (KW + 1)'(total));
  assign sts_o.lvl_last   = ((m_q + 3'd1) == lvl_cnt);
  assign sts_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cand_q <= CFG_W'(CFG_RESET);
    end else if (cfg_we_i) begin
      max_cand_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      common_q <= action_i;
      ncce_q   <= ncce_sat;
      sf_q     <= subframe_i;
      filt_q   <= level_filter_i;
      limit_q  <= limit_sat;
      y_q      <= Y_W'(rnti_i);
      step_q   <= '0;
      lvl_q    <= '0;
      k_q      <= '0;
    end
    if (cmd_i.hash_mul) begin
      prod_q <= PROD_W'(32'(y_q) * 32'(HASH_MULT));
    end
    if (cmd_i.hash_red) begin
      y_q    <= y_red;
      step_q <= step_q + 4'd1;
    end
    if (cmd_i.lvl_next) begin
      lvl_q <= lvl_q + 2'd1;
    end
    if (cmd_i.div_load) begin
      divq_q   <= y_q;
      divcnt_q <= '0;
      r_q      <= '0;
      m_q      <= '0;
    end
    if (cmd_i.div_step) begin
      divq_q   <= {divq_q[Y_W-2:0], 1'b0};
      divcnt_q <= divcnt_q + 5'd1;
      r_q      <= rem[NCCE_W-1:0];
    end
    if (cmd_i.cand_init) begin
      r_q <= '0;
      m_q <= '0;
    end
    if (cmd_i.emit) begin
      k_q <= k_q + KW'(1);
      m_q <= m_q + 3'd1;
      r_q <= r_inc;
      if (sts_o.lvl_last) begin
        lvl_q <= lvl_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.mark) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      valid_res_q  <= 1'b1;
      level_log2_q <= lvl_q;
      start_cce_q  <= r_q << lvl_q;
      cand_index_q <= IDX_W'(k_q);
      last_q       <= sts_o.emit_last;
    end else if (cmd_i.mark) begin
      valid_res_q  <= 1'b0;
      level_log2_q <= '0;
      start_cce_q  <= '0;
      cand_index_q <= '0;
      last_q       <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign valid_res_o  = valid_res_q;
  assign level_log2_o = level_log2_q;
  assign start_cce_o  = start_cce_q;
  assign cand_index_o = cand_index_q;
  assign last_o       = last_q;

endmodule
